// ----- design/pwo_pkg.sv -----
// Shared types, constants and the sine table of the phased waveform oscillator.
package pwo_pkg;

    localparam int SINE_DEPTH = 1024;
    localparam int SINE_AW    = $clog2(SINE_DEPTH);
    localparam int QDEPTH     = 4;
    localparam int QAW        = $clog2(QDEPTH);

    typedef enum logic [2:0] {
        SHAPE_SINE      = 3'd0,
        SHAPE_COSINE    = 3'd1,
        SHAPE_RAMP_UP   = 3'd2,
        SHAPE_RAMP_DOWN = 3'd3,
        SHAPE_PULSE     = 3'd4,
        SHAPE_TRIANGLE  = 3'd5
    } t_shape;

    typedef enum logic [2:0] {
        REG_WAVE_SHAPE      = 3'd0,
        REG_PERIOD_US       = 3'd1,
        REG_LEVEL_MIN       = 3'd2,
        REG_LEVEL_MAX       = 3'd3,
        REG_DUTY_WIDTH      = 3'd4,
        REG_PHASE_OFFSET    = 3'd5,
        REG_SWEEP_DIRECTION = 3'd6,
        REG_STEP_SPREAD     = 3'd7
    } t_reg_idx;

    // Effective settings: zero period, spread and width already forced to one
    typedef struct packed {
        logic [2:0]  shape;
        logic [31:0] period;
        logic [15:0] lmin;
        logic [15:0] lmax;
        logic [15:0] duty;
        logic [15:0] offset;
        logic        dir;
        logic [12:0] spread;
    } t_cfg;

    typedef struct packed {
        logic        vld;
        logic [15:0] pos;
    } t_pos_item;

    typedef logic [15:0] t_sine_rom [SINE_DEPTH];

    function automatic logic [15:0] sine_entry(input longint unsigned k);
        longint unsigned t;
        longint unsigned r;
        longint unsigned thu;
        longint unsigned biased;
        logic [1:0]      q;
        longint          th;
        longint          th2;
        longint          term;
        longint          sum;
        logic [63:0]     res;
        t = (k * 64'd65536) / SINE_DEPTH;
        q = t[15:14];
        r = t & 64'h3FFF;
        if (q[0]) begin
            r = 64'd16384 - r;
        end
        thu  = (r * 64'd1686629713) >> 14;
        th   = longint'(thu);
        th2  = longint'((thu * thu) >> 30);
        term = th;
        sum  = th;
        term = -((term * th2) / 64'sd1073741824);
        term = term / 64'sd6;
        sum  = sum + term;
        term = -((term * th2) / 64'sd1073741824);
        term = term / 64'sd20;
        sum  = sum + term;
        term = -((term * th2) / 64'sd1073741824);
        term = term / 64'sd42;
        sum  = sum + term;
        term = -((term * th2) / 64'sd1073741824);
        term = term / 64'sd72;
        sum  = sum + term;
        term = -((term * th2) / 64'sd1073741824);
        term = term / 64'sd110;
        sum  = sum + term;
        term = -((term * th2) / 64'sd1073741824);
        term = term / 64'sd156;
        sum  = sum + term;
        if (sum < 0) begin
            sum = 0;
        end
        if (sum > 64'sd1073741824) begin
            sum = 64'sd1073741824;
        end
        if (q[1]) begin
            biased = longint'(64'sd1073741824 - sum);
        end else begin
            biased = longint'(64'sd1073741824 + sum);
        end
        res = (64'd65535 * biased + 64'd1073741824) >> 31;
        return res[15:0];
    endfunction

    function automatic t_sine_rom build_sine();
        t_sine_rom rom;
        for (int k = 0; k < SINE_DEPTH; k++) begin
            rom[k] = sine_entry(64'(k));
        end
        return rom;
    endfunction

    localparam t_sine_rom SINE_ROM = build_sine();

endpackage

// ----- design/pwo_front.sv -----
// Front pipeline: step phase, time reduction and position in the cycle.
module pwo_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pwo_pkg::t_cfg      i_cfg,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [31:0]        i_time_us,
    input  logic [15:0]        i_pixel_step,
    input  logic               i_full,
    output pwo_pkg::t_pos_item o_item
);
    import pwo_pkg::*;

    localparam int NA   = 32;          // time remainder, step remainder, phase fraction
    localparam int NP   = 16;          // position quotient bits
    localparam int NSTG = NA + 3 + NP;

    logic [NSTG-1:0] r_vld;
    logic            en;

    logic [31:0] r_tim  [NA];
    logic [31:0] r_trem [NA];
    logic [15:0] r_stp  [NA];
    logic [12:0] r_srem [NA];
    logic [15:0] r_fq   [NA];

    logic [15:0] r_ph;
    logic [31:0] r_trem_a;
    logic [31:0] r_b;
    logic [31:0] r_trem_b;
    logic [31:0] r_pt;

    logic [31:0] r_prem [NP];
    logic [15:0] r_pq   [NP];

    assign en      = !r_vld[NSTG-1] || !i_full;
    assign o_stall = !en;
    assign o_item.vld = r_vld[NSTG-1] && !i_full;
    assign o_item.pos = r_pq[NP-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NSTG-2:0], i_valid};
        end
    end

    genvar j;
    generate
        for (j = 0; j < NA; j++) begin : g_a
            logic [31:0] tim_in, trem_in, trem_out;
            logic [15:0] stp_in, fq_in, fq_out, stp_out;
            logic [12:0] srem_in, srem_out;
            logic [32:0] t_sh;
            logic [13:0] s_sh;
            logic        t_ge, s_ge;
            if (j == 0) begin : g_in
                assign tim_in  = i_time_us;
                assign trem_in = '0;
                assign stp_in  = i_pixel_step;
                assign srem_in = '0;
                assign fq_in   = '0;
            end else begin : g_in
                assign tim_in  = r_tim[j-1];
                assign trem_in = r_trem[j-1];
                assign stp_in  = r_stp[j-1];
                assign srem_in = r_srem[j-1];
                assign fq_in   = r_fq[j-1];
            end
            always_comb begin
                t_sh     = {trem_in, tim_in[31]};
                t_ge     = t_sh >= {1'b0, i_cfg.period};
                trem_out = t_ge ? 32'(t_sh - {1'b0, i_cfg.period}) : t_sh[31:0];
                if (j < 16) begin
                    // step mod spread
                    s_sh    = {srem_in, stp_in[15]};
                    stp_out = {stp_in[14:0], 1'b0};
                end else begin
                    // fraction of a turn, one quotient bit
                    s_sh    = {srem_in, 1'b0};
                    stp_out = stp_in;
                end
                s_ge     = s_sh >= {1'b0, i_cfg.spread};
                srem_out = s_ge ? 13'(s_sh - {1'b0, i_cfg.spread}) : s_sh[12:0];
                fq_out   = (j < 16) ? fq_in : {fq_in[14:0], s_ge};
            end
            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_tim[j]  <= {tim_in[30:0], 1'b0};
                    r_trem[j] <= trem_out;
                    r_stp[j]  <= stp_out;
                    r_srem[j] <= srem_out;
                    r_fq[j]   <= fq_out;
                end
            end
        end
    endgenerate

    logic [47:0] prod;
    logic [32:0] ptsum;

    always_comb begin
        prod  = 48'(r_ph) * 48'(i_cfg.period);
        ptsum = {1'b0, r_trem_b} + {1'b0, r_b};
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            // mirror the phase when the sweep direction bit is clear
            r_ph     <= i_cfg.dir ? 16'(r_fq[NA-1] + i_cfg.offset)
                                  : 16'(i_cfg.offset - r_fq[NA-1]);
            r_trem_a <= r_trem[NA-1];
            r_b      <= prod[47:16];
            r_trem_b <= r_trem_a;
            r_pt     <= (ptsum >= {1'b0, i_cfg.period}) ?
                        32'(ptsum - {1'b0, i_cfg.period}) : ptsum[31:0];
        end
    end

    genvar k;
    generate
        for (k = 0; k < NP; k++) begin : g_p
            logic [31:0] rem_in, rem_out;
            logic [15:0] q_in;
            logic [32:0] sh;
            logic        ge;
            if (k == 0) begin : g_in
                assign rem_in = r_pt;
                assign q_in   = '0;
            end else begin : g_in
                assign rem_in = r_prem[k-1];
                assign q_in   = r_pq[k-1];
            end
            always_comb begin
                sh      = {rem_in, 1'b0};
                ge      = sh >= {1'b0, i_cfg.period};
                rem_out = ge ? 32'(sh - {1'b0, i_cfg.period}) : sh[31:0];
            end
            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_prem[k] <= rem_out;
                    r_pq[k]   <= {q_in[14:0], ge};
                end
            end
        end
    endgenerate

endmodule

// ----- design/pwo_fifo.sv -----
// Short position queue between the front and back pipelines.
module pwo_fifo (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pwo_pkg::t_pos_item i_push,
    input  logic               i_pop,
    output pwo_pkg::t_pos_item o_head,
    output logic               o_full
);
    import pwo_pkg::*;

    logic [15:0]    r_mem [QDEPTH];
    logic [QAW-1:0] r_wr;
    logic [QAW-1:0] r_rd;
    logic [QAW:0]   r_cnt;
    logic           pop;

    assign o_full     = (r_cnt == (QAW+1)'(QDEPTH));
    assign o_head.vld = (r_cnt != '0);
    assign o_head.pos = r_mem[r_rd];
    assign pop        = i_pop && o_head.vld;

    always_ff @(posedge i_clk) begin
        if (i_push.vld) begin
            r_mem[r_wr] <= i_push.pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push.vld) begin
                r_wr <= r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push.vld && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !i_push.vld) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (QAW+1)'(QDEPTH))
        else $error("queue count beyond depth");
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push.vld)
        else $error("transfer into a full queue");
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !i_push.vld) |=> r_cnt == $past(r_cnt) - 1'b1)
        else $error("queue count did not drop on pop");

endmodule

// ----- design/pwo_back.sv -----
// Back pipeline: waveform selection, sine lookup and scaling between the bounds.
module pwo_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pwo_pkg::t_cfg      i_cfg,
    input  pwo_pkg::t_pos_item i_item,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [15:0]        o_level
);
    import pwo_pkg::*;

    localparam int ND   = 16;
    localparam int NSTG = ND + 4;

    logic [NSTG-1:0] r_vld;
    logic            en;

    logic [15:0] r_tab;
    logic [15:0] r_pos;
    logic [15:0] r_num;
    logic [15:0] r_den;
    logic [31:0] r_prod;
    logic [15:0] r_pden;
    logic [15:0] r_drem [ND];
    logic [15:0] r_dlo  [ND];
    logic [15:0] r_dq   [ND];
    logic [15:0] r_dden [ND];
    logic [15:0] r_level;

    assign en      = !r_vld[NSTG-1] || !i_stall;
    assign o_pop   = i_item.vld && en;
    assign o_valid = r_vld[NSTG-1];
    assign o_level = r_level;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NSTG-2:0], o_pop};
        end
    end

    // Table lookup; cosine reads a quarter turn ahead
    logic [15:0]        ipos;
    logic [31:0]        iprod;
    logic [SINE_AW-1:0] idx;

    always_comb begin
        ipos  = (i_cfg.shape == SHAPE_COSINE) ? 16'(i_item.pos + 16'd16384) : i_item.pos;
        iprod = (32'(ipos) * 32'(SINE_DEPTH)) >> 16;
        idx   = iprod[SINE_AW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_tab <= SINE_ROM[idx];
            r_pos <= i_item.pos;
        end
    end

    // Fraction num/den of the span for the chosen shape
    logic [15:0] num, den, w, d;
    logic [16:0] p2, lim;

    always_comb begin
        w   = i_cfg.duty;
        den = w;
        num = '0;
        lim = 17'h10000 - {1'b0, w};
        d   = 16'(r_pos + w);
        p2  = {r_pos, 1'b0};
        unique case (t_shape'(i_cfg.shape)) inside
            SHAPE_SINE, SHAPE_COSINE: begin
                num = r_tab;
                den = 16'hFFFF;
            end
            SHAPE_RAMP_UP: begin
                num = ({1'b0, r_pos} > lim) ? d : '0;
            end
            SHAPE_RAMP_DOWN: begin
                num = ({1'b0, r_pos} > lim) ? 16'(w - d) : '0;
            end
            SHAPE_PULSE: begin
                num = (r_pos < w) ? w : '0;
            end
            SHAPE_TRIANGLE: begin
                if (p2 < {1'b0, w}) begin
                    num = p2[15:0];
                end else if (r_pos < w) begin
                    num = 16'({w, 1'b0} - p2);
                end
            end
            default: begin
                num = '0;
            end
        endcase
    end

    logic [15:0] span;
    logic        inv;

    always_comb begin
        inv  = i_cfg.lmax < i_cfg.lmin;
        span = inv ? 16'(i_cfg.lmin - i_cfg.lmax) : 16'(i_cfg.lmax - i_cfg.lmin);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_num  <= num;
            r_den  <= den;
            r_prod <= 32'(span) * 32'(r_num);
            r_pden <= r_den;
        end
    end

    // Restoring division of span*num by den, one quotient bit a stage
    genvar k;
    generate
        for (k = 0; k < ND; k++) begin : g_d
            logic [15:0] rem_in, lo_in, q_in, den_in, rem_out;
            logic [16:0] sh;
            logic        ge;
            if (k == 0) begin : g_in
                assign rem_in = r_prod[31:16];
                assign lo_in  = r_prod[15:0];
                assign q_in   = '0;
                assign den_in = r_pden;
            end else begin : g_in
                assign rem_in = r_drem[k-1];
                assign lo_in  = r_dlo[k-1];
                assign q_in   = r_dq[k-1];
                assign den_in = r_dden[k-1];
            end
            always_comb begin
                sh      = {rem_in, lo_in[15]};
                ge      = sh >= {1'b0, den_in};
                rem_out = ge ? 16'(sh - {1'b0, den_in}) : sh[15:0];
            end
            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_drem[k] <= rem_out;
                    r_dlo[k]  <= {lo_in[14:0], 1'b0};
                    r_dq[k]   <= {q_in[14:0], ge};
                    r_dden[k] <= den_in;
                end
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_level <= inv ? 16'(i_cfg.lmin - r_dq[ND-1]) : 16'(i_cfg.lmin + r_dq[ND-1]);
        end
    end

endmodule

// ----- design/phased_waveform_oscillator_core.sv -----
// Top level of the phased waveform oscillator: settings, front, queue and back.
//
// channel   direction  handshake                 payload
// input     in         i_valid / o_stall         i_time_us, i_pixel_step
// result    out        o_valid / i_stall         o_level
// settings  in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// One item enters per cycle while o_stall is low; a result passes 51 front stages,
// a queue slot and 20 back stages, most of them bit-serial divider stages.
// Reset is synchronous, clears the valid bits and the queue, and loads the default settings.
// A stall at the output holds the back pipeline; the four-entry queue lets the
// front run on until it fills, and only then is the input stalled.
module phased_waveform_oscillator_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_time_us,
    input  logic [15:0] i_pixel_step,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_level,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    import pwo_pkg::*;

    logic [2:0]  r_shape;
    logic [31:0] r_period;
    logic [15:0] r_lmin;
    logic [15:0] r_lmax;
    logic [15:0] r_duty;
    logic [15:0] r_offset;
    logic        r_dir;
    logic [12:0] r_spread;

    t_cfg      cfg;
    t_pos_item push;
    t_pos_item head;
    logic      full;
    logic      pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shape  <= SHAPE_SINE;
            r_period <= 32'd1000000;
            r_lmin   <= 16'd0;
            r_lmax   <= 16'd65535;
            r_duty   <= 16'd32768;
            r_offset <= 16'd0;
            r_dir    <= 1'b0;
            r_spread <= 13'd1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_WAVE_SHAPE:      r_shape  <= i_cfg_data[2:0];
                REG_PERIOD_US:       r_period <= i_cfg_data;
                REG_LEVEL_MIN:       r_lmin   <= i_cfg_data[15:0];
                REG_LEVEL_MAX:       r_lmax   <= i_cfg_data[15:0];
                REG_DUTY_WIDTH:      r_duty   <= i_cfg_data[15:0];
                REG_PHASE_OFFSET:    r_offset <= i_cfg_data[15:0];
                REG_SWEEP_DIRECTION: r_dir    <= i_cfg_data[0];
                REG_STEP_SPREAD:     r_spread <= i_cfg_data[12:0];
                default: begin
                end
            endcase
        end
    end

    // Treat zero period, spread and width as one
    always_comb begin
        cfg.shape  = r_shape;
        cfg.period = (r_period == '0) ? 32'd1 : r_period;
        cfg.lmin   = r_lmin;
        cfg.lmax   = r_lmax;
        cfg.duty   = (r_duty == '0) ? 16'd1 : r_duty;
        cfg.offset = r_offset;
        cfg.dir    = r_dir;
        cfg.spread = (r_spread == '0) ? 13'd1 : r_spread;
    end

    pwo_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_time_us    (i_time_us),
        .i_pixel_step (i_pixel_step),
        .i_full       (full),
        .o_item       (push)
    );

    pwo_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_head  (head),
        .o_full  (full)
    );

    pwo_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_item  (head),
        .o_pop   (pop),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_level (o_level)
    );

endmodule

// ----- verif/tb_phased_waveform_oscillator_core.sv -----
// Self-checking testbench for the phased waveform oscillator core.
`timescale 1ns / 1ps

module tb_phased_waveform_oscillator_core;
    import pwo_pkg::*;

    localparam int LATENCY = 80;
    localparam int CYCLE_LIMIT = 400000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [31:0] i_time_us;
    logic [15:0] i_pixel_step;
    logic        o_valid;
    logic        i_stall;
    logic [15:0] o_level;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [31:0] i_cfg_data;

    phased_waveform_oscillator_core u_dut (.*);

    // Own copy of the settings, as written
    logic [2:0]  shape_q;
    logic [31:0] period_q;
    logic [15:0] lmin_q;
    logic [15:0] lmax_q;
    logic [15:0] duty_q;
    logic [15:0] offset_q;
    logic        dir_q;
    logic [12:0] spread_q;

    logic [15:0] sine_lut [1024];
    logic [15:0] level_queue [$];
    int          mismatches;
    int          cycles;
    bit          rx_stall_mode;

    // Quarter-folded Taylor sine, Q30, thirteenth power
    function automatic logic [15:0] sine_value(int k);
        longint unsigned t, r, thu, biased;
        longint th, th2, term, sum;
        logic [63:0] res;
        t = (longint'(k) * 65536) / 1024;
        r = t & 16'h3FFF;
        if (t[14]) r = 16384 - r;
        thu = (r * 64'd1686629713) >> 14;
        th = longint'(thu);
        th2 = longint'((thu * thu) >> 30);
        term = th;
        sum = th;
        for (int n = 1; n <= 6; n++) begin
            term = -((term * th2) / 64'sd1073741824);
            term = term / longint'((2 * n) * (2 * n + 1));
            sum += term;
        end
        if (sum < 0) sum = 0;
        if (sum > 64'sd1073741824) sum = 64'sd1073741824;
        biased = t[15] ? longint'(64'sd1073741824 - sum) : longint'(64'sd1073741824 + sum);
        res = (64'd65535 * biased + 64'd1073741824) >> 31;
        return res[15:0];
    endfunction

    function automatic logic [15:0] scaled_level(longint unsigned num, longint unsigned den);
        longint unsigned lo, hi;
        lo = lmin_q;
        hi = lmax_q;
        if (hi >= lo) return 16'(lo + ((hi - lo) * num) / den);
        return 16'(lo - ((lo - hi) * num) / den);
    endfunction

    function automatic logic [15:0] predict_level(logic [31:0] t_us, logic [15:0] step);
        longint unsigned per, spr, w, s, f, ph, pt, pos, p2, d;
        per = (period_q == 0) ? 1 : period_q;
        spr = (spread_q == 0) ? 1 : spread_q;
        w = (duty_q == 0) ? 1 : duty_q;
        s = step % spr;
        f = (s * 65536) / spr;
        if (dir_q) ph = (f + offset_q) & 16'hFFFF;
        else ph = (65536 - f + offset_q) & 16'hFFFF;
        pt = ((t_us % per) + (ph * per) / 65536) % per;
        pos = (pt * 65536) / per;
        case (shape_q)
            SHAPE_SINE:   return scaled_level(sine_lut[(pos * 1024) >> 16], 65535);
            SHAPE_COSINE: begin
                p2 = (pos + 16384) & 16'hFFFF;
                return scaled_level(sine_lut[(p2 * 1024) >> 16], 65535);
            end
            SHAPE_RAMP_UP, SHAPE_RAMP_DOWN: begin
                if (pos > 65536 - w) begin
                    d = pos - (65536 - w);
                    return (shape_q == SHAPE_RAMP_UP) ? scaled_level(d, w)
                                                      : scaled_level(w - d, w);
                end
                return lmin_q;
            end
            SHAPE_PULSE:  return (pos < w) ? lmax_q : lmin_q;
            SHAPE_TRIANGLE: begin
                if (2 * pos < w) return scaled_level(2 * pos, w);
                if (pos < w) return scaled_level(2 * w - 2 * pos, w);
                return lmin_q;
            end
            default: return lmin_q;
        endcase
    endfunction

    initial begin
        i_clk = 1'b0;
        forever begin
            #5 i_clk = 1'b1;
            #5 i_clk = 1'b0;
        end
    end

    task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    // Check each result transfer against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (level_queue.size() == 0) begin
                report_mismatch("unexpected level", o_level, 16'd0);
            end else begin
                if (o_level !== level_queue[0])
                    report_mismatch("level", o_level, level_queue[0]);
                void'(level_queue.pop_front());
            end
        end
    end

    // Receiver stall pattern: random independent stalls, or none at all
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (rx_stall_mode) begin
            i_stall <= ($urandom_range(0, 99) < 35);
        end else begin
            i_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic send_item(logic [31:0] t_us, logic [15:0] step);
        i_valid      <= 1'b1;
        i_time_us    <= t_us;
        i_pixel_step <= step;
        do @(posedge i_clk); while (o_stall);
        level_queue.push_back(predict_level(t_us, step));
    endtask

    task automatic drop_valid();
        i_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Random burst gaps between transfers
    task automatic maybe_gap();
        if ($urandom_range(0, 7) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    task automatic write_reg(t_reg_idx idx, logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            REG_WAVE_SHAPE:      shape_q  = data[2:0];
            REG_PERIOD_US:       period_q = data;
            REG_LEVEL_MIN:       lmin_q   = data[15:0];
            REG_LEVEL_MAX:       lmax_q   = data[15:0];
            REG_DUTY_WIDTH:      duty_q   = data[15:0];
            REG_PHASE_OFFSET:    offset_q = data[15:0];
            REG_SWEEP_DIRECTION: dir_q    = data[0];
            REG_STEP_SPREAD:     spread_q = data[12:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // Hold until the pipeline has drained
    task automatic drain();
        drop_valid();
        while (level_queue.size() != 0) @(posedge i_clk);
        repeat (LATENCY) @(posedge i_clk);
    endtask

    task automatic test_reset_settings();
        send_item(32'd0, 16'd0);
        send_item(32'd250000, 16'd3);
        send_item(32'hFFFF_FFFF, 16'hFFFF);
        send_item(32'd750000, 16'h8000);
        drain();
    endtask

    task automatic test_shapes_directed();
        for (int sh = 0; sh < 8; sh++) begin
            write_reg(REG_WAVE_SHAPE, sh);
            write_reg(REG_PERIOD_US, 32'd1000);
            write_reg(REG_STEP_SPREAD, 13'd8);
            send_item(32'd0, 16'd0);
            send_item(32'd999, 16'd5);
            send_item(32'd500, 16'hFFFF);
            drain();
        end
    endtask

    task automatic test_special_cases();
        write_reg(REG_WAVE_SHAPE, SHAPE_TRIANGLE);
        write_reg(REG_PERIOD_US, 32'd0);
        write_reg(REG_STEP_SPREAD, 13'd0);
        write_reg(REG_DUTY_WIDTH, 16'd0);
        send_item(32'd7, 16'd9);
        drain();
        write_reg(REG_PERIOD_US, 32'hFFFF_FFFF);
        write_reg(REG_STEP_SPREAD, 13'h1FFF);
        write_reg(REG_DUTY_WIDTH, 16'hFFFF);
        write_reg(REG_LEVEL_MIN, 16'hFFFF);
        write_reg(REG_LEVEL_MAX, 16'd0);
        write_reg(REG_SWEEP_DIRECTION, 1'b1);
        write_reg(REG_PHASE_OFFSET, 16'hFFFF);
        send_item(32'h8000_0000, 16'h1234);
        send_item(32'hFFFF_FFFE, 16'hFFFF);
        drain();
    endtask

    task automatic randomise_settings(bit extreme);
        write_reg(REG_WAVE_SHAPE, $urandom_range(0, 7));
        write_reg(REG_PERIOD_US, extreme ? ($urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd1)
                                         : ($urandom_range(0, 1) ? $urandom : $urandom_range(0, 5000)));
        write_reg(REG_LEVEL_MIN, $urandom_range(0, 65535));
        write_reg(REG_LEVEL_MAX, $urandom_range(0, 65535));
        write_reg(REG_DUTY_WIDTH, extreme ? ($urandom_range(0, 1) ? 16'hFFFF : 16'd1)
                                          : $urandom_range(0, 65535));
        write_reg(REG_PHASE_OFFSET, $urandom_range(0, 65535));
        write_reg(REG_SWEEP_DIRECTION, $urandom_range(0, 1));
        write_reg(REG_STEP_SPREAD, $urandom_range(0, 1) ? $urandom_range(0, 64)
                                                        : $urandom_range(0, 8191));
    endtask

    task automatic test_random_phases();
        for (int ph = 0; ph < 32; ph++) begin
            randomise_settings(ph % 5 == 0);
            rx_stall_mode = (ph % 3 != 0);
            for (int n = 0; n < 50; n++) begin
                maybe_gap();
                send_item($urandom, $urandom_range(0, 65535));
            end
            drain();
        end
    endtask

    initial begin
        mismatches    = 0;
        cycles        = 0;
        rx_stall_mode = 1'b0;
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_time_us     = '0;
        i_pixel_step  = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = REG_WAVE_SHAPE;
        i_cfg_data    = '0;
        for (int k = 0; k < 1024; k++) sine_lut[k] = sine_value(k);
        shape_q  = SHAPE_SINE;
        period_q = 32'd1000000;
        lmin_q   = 16'd0;
        lmax_q   = 16'hFFFF;
        duty_q   = 16'd32768;
        offset_q = 16'd0;
        dir_q    = 1'b0;
        spread_q = 13'd1;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_settings();
        test_shapes_directed();
        test_special_cases();
        test_random_phases();

        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
